// File: src/pooled_doubly_linked_list_macros.svh
// Assertion macros used by the checker file of the pooled linked list.
`ifndef POOLED_DOUBLY_LINKED_LIST_MACROS_SVH
`define POOLED_DOUBLY_LINKED_LIST_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PDLL_ASSERT_IMP(lbl, ck, rn, a, c, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PDLL_ASSERT_NXT(lbl, ck, rn, a, c, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) else $error(msg);

`endif

// File: src/pdll_pkg.sv
// Shared constants, operation codes, controller states, commands and status for the list.
package pdll_pkg;

    localparam int NODES  = 256;
    localparam int ADDR_W = $clog2(NODES);
    localparam int PTR_W  = ADDR_W + 1;
    localparam int CNT_W  = PTR_W;
    localparam int DATA_W = 32;

    localparam logic [PTR_W-1:0] NIL = PTR_W'(NODES);

    typedef enum logic [3:0] {
        K_PUSH_BACK  = 4'd0,
        K_PUSH_FRONT = 4'd1,
        K_INSERT     = 4'd2,
        K_ERASE      = 4'd3,
        K_REPLACE    = 4'd4,
        K_POP_FRONT  = 4'd5,
        K_POP_BACK   = 4'd6,
        K_READ_FRONT = 4'd7,
        K_READ_BACK  = 4'd8,
        K_READ_NODE  = 4'd9,
        K_AT_INDEX   = 4'd10,
        K_FIND       = 4'd11,
        K_REMOVE_EQ  = 4'd12,
        K_UNIQUE     = 4'd13,
        K_REVERSE    = 4'd14,
        K_CLEAR      = 4'd15
    } kind_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_NQ,
        S_ALLOC,
        S_ALLOC2,
        S_PLINK,
        S_REL,
        S_AW,
        S_AWS,
        S_FL,
        S_FQ,
        S_RE,
        S_REQ,
        S_UP,
        S_UPQ,
        S_UC,
        S_UCQ,
        S_UPN,
        S_RV,
        S_RVQ,
        S_CL,
        S_CLQ,
        S_DONE
    } state_t;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_RD_N,
        CMD_RD_CUR,
        CMD_RD_FREE,
        CMD_RD_BASE,
        CMD_PTAIL,
        CMD_PPOS,
        CMD_ALLOC,
        CMD_PLINK,
        CMD_UNLINK,
        CMD_RELEASE,
        CMD_REPL,
        CMD_REPORT,
        CMD_AW_STEP,
        CMD_FNEXT,
        CMD_UBASE,
        CMD_UADV,
        CMD_RVSWAP,
        CMD_RVEND,
        CMD_CLREL,
        CMD_CLEND,
        CMD_BULK,
        CMD_EMIT
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  given;
        logic  x_nil;
        logic  n_nil;
        logic  cur_nil;
        logic  base_nil;
        logic  free_nil;
        logic  idx_oob;
        logic  steps_zero;
        logic  q_live;
        logic  q_match;
        logic  q_bmatch;
        logic  out_free;
    } status_t;

endpackage

// File: src/pdll_ctrl.sv
// Sequencer that steps each list operation through datapath commands.
module pdll_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  pdll_pkg::status_t st,
    output pdll_pkg::cmd_t    cmd
);
    import pdll_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (st.kind) inside
                    K_PUSH_BACK, K_PUSH_FRONT, K_INSERT:
                    begin
                        if (st.x_nil)
                        begin
                            cmd        = CMD_PTAIL;
                            state_next = S_ALLOC;
                        end
                        else
                        begin
                            cmd        = CMD_RD_N;
                            state_next = S_NQ;
                        end
                    end
                    K_ERASE, K_REPLACE, K_POP_FRONT, K_POP_BACK,
                    K_READ_FRONT, K_READ_BACK, K_READ_NODE:
                    begin
                        if (st.n_nil)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd        = CMD_RD_N;
                            state_next = S_NQ;
                        end
                    end
                    K_AT_INDEX:
                    begin
                        state_next = st.idx_oob ? S_DONE : S_AW;
                    end
                    K_FIND:
                    begin
                        if (st.given)
                        begin
                            cmd        = CMD_RD_N;
                            state_next = S_NQ;
                        end
                        else
                        begin
                            state_next = S_FL;
                        end
                    end
                    K_REMOVE_EQ: state_next = S_RE;
                    K_UNIQUE:    state_next = S_UP;
                    K_REVERSE:   state_next = S_RV;
                    default:     state_next = S_CL;
                endcase
            end
            S_NQ:
            begin
                state_next = S_DONE;
                unique case (st.kind) inside
                    K_PUSH_BACK, K_PUSH_FRONT, K_INSERT:
                    begin
                        if (st.kind != K_INSERT || st.q_live)
                        begin
                            cmd        = CMD_PPOS;
                            state_next = S_ALLOC;
                        end
                    end
                    K_ERASE, K_POP_FRONT, K_POP_BACK:
                    begin
                        if (st.kind != K_ERASE || st.q_live)
                        begin
                            cmd        = CMD_UNLINK;
                            state_next = S_REL;
                        end
                    end
                    K_REPLACE:
                    begin
                        if (st.q_live)
                        begin
                            cmd = CMD_REPL;
                        end
                    end
                    K_READ_FRONT, K_READ_BACK, K_READ_NODE, K_AT_INDEX:
                    begin
                        if (st.kind != K_READ_NODE || st.q_live)
                        begin
                            cmd = CMD_REPORT;
                        end
                    end
                    K_FIND:
                    begin
                        if (st.q_live)
                        begin
                            cmd        = CMD_FNEXT;
                            state_next = S_FL;
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_ALLOC:
            begin
                if (st.free_nil)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = CMD_RD_FREE;
                    state_next = S_ALLOC2;
                end
            end
            S_ALLOC2:
            begin
                cmd        = CMD_ALLOC;
                state_next = S_PLINK;
            end
            S_PLINK:
            begin
                cmd        = CMD_PLINK;
                state_next = S_DONE;
            end
            S_REL:
            begin
                cmd = CMD_RELEASE;
                if (st.kind == K_REMOVE_EQ)
                begin
                    state_next = S_RE;
                end
                else if (st.kind == K_UNIQUE)
                begin
                    state_next = S_UC;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_AW:
            begin
                cmd        = CMD_RD_N;
                state_next = st.steps_zero ? S_NQ : S_AWS;
            end
            S_AWS:
            begin
                cmd        = CMD_AW_STEP;
                state_next = S_AW;
            end
            S_FL:
            begin
                if (st.cur_nil)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = CMD_RD_CUR;
                    state_next = S_FQ;
                end
            end
            S_FQ:
            begin
                if (st.q_match)
                begin
                    cmd        = CMD_REPORT;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = CMD_FNEXT;
                    state_next = S_FL;
                end
            end
            S_RE:
            begin
                if (st.cur_nil)
                begin
                    cmd        = CMD_BULK;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = CMD_RD_CUR;
                    state_next = S_REQ;
                end
            end
            S_REQ:
            begin
                if (st.q_match)
                begin
                    cmd        = CMD_UNLINK;
                    state_next = S_REL;
                end
                else
                begin
                    cmd        = CMD_FNEXT;
                    state_next = S_RE;
                end
            end
            S_UP:
            begin
                if (st.base_nil)
                begin
                    cmd        = CMD_BULK;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = CMD_RD_BASE;
                    state_next = S_UPQ;
                end
            end
            S_UPQ:
            begin
                cmd        = CMD_UBASE;
                state_next = S_UC;
            end
            S_UC:
            begin
                if (st.cur_nil)
                begin
                    cmd        = CMD_RD_BASE;
                    state_next = S_UPN;
                end
                else
                begin
                    cmd        = CMD_RD_CUR;
                    state_next = S_UCQ;
                end
            end
            S_UCQ:
            begin
                if (st.q_bmatch)
                begin
                    cmd        = CMD_UNLINK;
                    state_next = S_REL;
                end
                else
                begin
                    cmd        = CMD_FNEXT;
                    state_next = S_UC;
                end
            end
            S_UPN:
            begin
                cmd        = CMD_UADV;
                state_next = S_UP;
            end
            S_RV:
            begin
                if (st.cur_nil)
                begin
                    cmd        = CMD_RVEND;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = CMD_RD_CUR;
                    state_next = S_RVQ;
                end
            end
            S_RVQ:
            begin
                cmd        = CMD_RVSWAP;
                state_next = S_RV;
            end
            S_CL:
            begin
                if (st.cur_nil)
                begin
                    cmd        = CMD_CLEND;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = CMD_RD_CUR;
                    state_next = S_CLQ;
                end
            end
            S_CLQ:
            begin
                cmd        = CMD_CLREL;
                state_next = S_CL;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd        = CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// File: src/pdll_dp.sv
// Node tables, list pointers, walk registers and result register of the list.
module pdll_dp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pdll_pkg::cmd_t           cmd,
    output pdll_pkg::status_t        st,
    input  logic [3:0]               kind,
    input  logic [7:0]               node,
    input  logic                     node_given,
    input  logic [31:0]              value,
    input  logic signed [8:0]        index,
    input  logic                     out_stall,
    output logic                     out_valid,
    output logic                     ok,
    output logic [31:0]              data,
    output logic [7:0]               handle,
    output logic [7:0]               prev_node,
    output logic                     has_prev,
    output logic [7:0]               next_node,
    output logic                     has_next,
    output logic [8:0]               removed,
    output logic [8:0]               size
);
    import pdll_pkg::*;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] data;
        logic [ADDR_W-1:0] h;
        logic [ADDR_W-1:0] p;
        logic              hp;
        logic [ADDR_W-1:0] x;
        logic              hx;
    } res_t;

    function automatic res_t mk_res(input logic [PTR_W-1:0] h, input logic [PTR_W-1:0] p,
                                    input logic [PTR_W-1:0] x, input logic [DATA_W-1:0] d);
        res_t r;
        r.ok   = 1'b1;
        r.data = d;
        r.h    = h[ADDR_W-1:0];
        r.hp   = (p != NIL);
        r.p    = (p != NIL) ? p[ADDR_W-1:0] : '0;
        r.hx   = (x != NIL);
        r.x    = (x != NIL) ? x[ADDR_W-1:0] : '0;
        return r;
    endfunction

    // list state
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [PTR_W-1:0]  free_reg, free_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    // per-item working registers
    kind_t             kind_reg, kind_next;
    logic              given_reg, given_next;
    logic              dir_reg, dir_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [DATA_W-1:0] bval_reg, bval_next;
    logic [PTR_W-1:0]  n_reg, n_next;
    logic [PTR_W-1:0]  p_reg, p_next;
    logic [PTR_W-1:0]  x_reg, x_next;
    logic [PTR_W-1:0]  cur_reg, cur_next;
    logic [PTR_W-1:0]  base_reg, base_next;
    logic [PTR_W-1:0]  steps_reg, steps_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    res_t              res_reg, res_next;

    // output register
    logic              ov_reg, ov_next;
    res_t              ores_reg;
    logic [CNT_W-1:0]  orem_reg;
    logic [CNT_W-1:0]  osize_reg;

    // node tables
    logic [PTR_W-1:0]  next_mem [NODES];
    logic [PTR_W-1:0]  prev_mem [NODES];
    logic              live_mem [NODES];
    logic [DATA_W-1:0] data_mem [NODES];
    logic [NODES-1:0]  wv_reg;

    logic              nw_en, pw_en, lw_en, dw_en;
    logic [ADDR_W-1:0] nw_addr, pw_addr, lw_addr, dw_addr;
    logic [PTR_W-1:0]  nw_data, pw_data;
    logic              lw_data;
    logic [DATA_W-1:0] dw_data;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;

    logic [PTR_W-1:0]  qn_raw, qp_raw;
    logic              ql_raw;
    logic [DATA_W-1:0] qd_reg;
    logic [ADDR_W-1:0] qa_reg;
    logic              qwv_reg;
    logic [PTR_W-1:0]  q_next, q_prev;
    logic              q_live;

    logic [PTR_W-1:0]  nd;
    logic [PTR_W-1:0]  pos;
    logic [8:0]        idx_u;

    assign q_next = qwv_reg ? qn_raw : (PTR_W'(qa_reg) + PTR_W'(1));
    assign q_prev = qwv_reg ? qp_raw : NIL;
    assign q_live = qwv_reg & ql_raw;

    assign nd    = PTR_W'(node);
    assign idx_u = index;

    always_comb
    begin
        unique case (kind_t'(kind)) inside
            K_PUSH_BACK:  pos = NIL;
            K_PUSH_FRONT: pos = head_reg;
            default:      pos = node_given ? nd : NIL;
        endcase
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        free_next  = free_reg;
        count_next = count_reg;
        kind_next  = kind_reg;
        given_next = given_reg;
        dir_next   = dir_reg;
        val_next   = val_reg;
        bval_next  = bval_reg;
        n_next     = n_reg;
        p_next     = p_reg;
        x_next     = x_reg;
        cur_next   = cur_reg;
        base_next  = base_reg;
        steps_next = steps_reg;
        rem_next   = rem_reg;
        res_next   = res_reg;
        nw_en      = 1'b0;
        nw_addr    = n_reg[ADDR_W-1:0];
        nw_data    = free_reg;
        pw_en      = 1'b0;
        pw_addr    = n_reg[ADDR_W-1:0];
        pw_data    = NIL;
        lw_en      = 1'b0;
        lw_addr    = n_reg[ADDR_W-1:0];
        lw_data    = 1'b0;
        dw_en      = 1'b0;
        dw_addr    = n_reg[ADDR_W-1:0];
        dw_data    = val_reg;
        rd_en      = 1'b0;
        rd_addr    = n_reg;
        unique case (cmd)
            CMD_LOAD:
            begin
                kind_next  = kind_t'(kind);
                given_next = node_given;
                val_next   = value;
                dir_next   = idx_u[8];
                steps_next = PTR_W'(idx_u[8] ? ~idx_u : idx_u);
                x_next     = pos;
                cur_next   = head_reg;
                base_next  = head_reg;
                rem_next   = '0;
                res_next   = '0;
                unique case (kind_t'(kind)) inside
                    K_PUSH_BACK, K_PUSH_FRONT, K_INSERT: n_next = pos;
                    K_POP_FRONT, K_READ_FRONT:           n_next = head_reg;
                    K_POP_BACK, K_READ_BACK:             n_next = tail_reg;
                    K_AT_INDEX:                          n_next = idx_u[8] ? tail_reg : head_reg;
                    default:                             n_next = nd;
                endcase
            end
            CMD_RD_N:
            begin
                rd_en   = 1'b1;
                rd_addr = n_reg;
            end
            CMD_RD_CUR:
            begin
                rd_en   = 1'b1;
                rd_addr = cur_reg;
                n_next  = cur_reg;
            end
            CMD_RD_FREE:
            begin
                rd_en   = 1'b1;
                rd_addr = free_reg;
                n_next  = free_reg;
            end
            CMD_RD_BASE:
            begin
                rd_en   = 1'b1;
                rd_addr = base_reg;
            end
            CMD_PTAIL: p_next = tail_reg;
            CMD_PPOS:  p_next = q_prev;
            CMD_ALLOC:
            begin
                free_next = q_next;
                nw_en     = 1'b1;
                nw_data   = x_reg;
                pw_en     = 1'b1;
                pw_data   = p_reg;
                dw_en     = 1'b1;
                lw_en     = 1'b1;
                lw_data   = 1'b1;
            end
            CMD_PLINK:
            begin
                if (p_reg != NIL)
                begin
                    nw_en   = 1'b1;
                    nw_addr = p_reg[ADDR_W-1:0];
                    nw_data = n_reg;
                end
                else
                begin
                    head_next = n_reg;
                end
                if (x_reg == NIL)
                begin
                    tail_next = n_reg;
                end
                else
                begin
                    pw_en   = 1'b1;
                    pw_addr = x_reg[ADDR_W-1:0];
                    pw_data = n_reg;
                end
                count_next = count_reg + CNT_W'(1);
                res_next   = mk_res(n_reg, p_reg, x_reg, val_reg);
            end
            CMD_UNLINK:
            begin
                if (q_prev != NIL)
                begin
                    nw_en   = 1'b1;
                    nw_addr = q_prev[ADDR_W-1:0];
                    nw_data = q_next;
                end
                else
                begin
                    head_next = q_next;
                end
                if (q_next != NIL)
                begin
                    pw_en   = 1'b1;
                    pw_addr = q_next[ADDR_W-1:0];
                    pw_data = q_prev;
                end
                else
                begin
                    tail_next = q_prev;
                end
                lw_en = 1'b1;
            end
            CMD_RELEASE:
            begin
                nw_en      = 1'b1;
                pw_en      = 1'b1;
                free_next  = n_reg;
                count_next = count_reg - CNT_W'(1);
                cur_next   = q_next;
                if (kind_reg == K_REMOVE_EQ || kind_reg == K_UNIQUE)
                begin
                    rem_next = rem_reg + CNT_W'(1);
                end
                else
                begin
                    res_next = mk_res(n_reg, q_prev, q_next, qd_reg);
                end
            end
            CMD_REPL:
            begin
                dw_en    = 1'b1;
                res_next = mk_res(n_reg, q_prev, q_next, val_reg);
            end
            CMD_REPORT: res_next = mk_res(n_reg, q_prev, q_next, qd_reg);
            CMD_AW_STEP:
            begin
                n_next     = dir_reg ? q_prev : q_next;
                steps_next = steps_reg - PTR_W'(1);
            end
            CMD_FNEXT: cur_next = q_next;
            CMD_UBASE:
            begin
                bval_next = qd_reg;
                cur_next  = q_next;
            end
            CMD_UADV: base_next = q_next;
            CMD_RVSWAP:
            begin
                nw_en    = 1'b1;
                nw_data  = q_prev;
                pw_en    = 1'b1;
                pw_data  = q_next;
                cur_next = q_next;
            end
            CMD_RVEND:
            begin
                head_next   = tail_reg;
                tail_next   = head_reg;
                res_next.ok = 1'b1;
            end
            CMD_CLREL:
            begin
                lw_en     = 1'b1;
                pw_en     = 1'b1;
                nw_en     = 1'b1;
                free_next = n_reg;
                cur_next  = q_next;
            end
            CMD_CLEND:
            begin
                head_next   = NIL;
                tail_next   = NIL;
                count_next  = '0;
                res_next.ok = 1'b1;
            end
            CMD_BULK: res_next.ok = 1'b1;
            default: ;
        endcase
    end

    assign ov_next = (cmd == CMD_EMIT) | (ov_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= NIL;
            tail_reg  <= NIL;
            free_reg  <= '0;
            count_reg <= '0;
            ov_reg    <= 1'b0;
            wv_reg    <= '0;
            qwv_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            free_reg  <= free_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
            if (lw_en)
            begin
                wv_reg[lw_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                qwv_reg <= wv_reg[rd_addr[ADDR_W-1:0]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        given_reg <= given_next;
        dir_reg   <= dir_next;
        val_reg   <= val_next;
        bval_reg  <= bval_next;
        n_reg     <= n_next;
        p_reg     <= p_next;
        x_reg     <= x_next;
        cur_reg   <= cur_next;
        base_reg  <= base_next;
        steps_reg <= steps_next;
        rem_reg   <= rem_next;
        res_reg   <= res_next;
        if (cmd == CMD_EMIT)
        begin
            ores_reg  <= res_reg;
            orem_reg  <= rem_reg;
            osize_reg <= count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (nw_en)
        begin
            next_mem[nw_addr] <= nw_data;
        end
        if (pw_en)
        begin
            prev_mem[pw_addr] <= pw_data;
        end
        if (lw_en)
        begin
            live_mem[lw_addr] <= lw_data;
        end
        if (dw_en)
        begin
            data_mem[dw_addr] <= dw_data;
        end
        if (rd_en)
        begin
            qn_raw <= next_mem[rd_addr[ADDR_W-1:0]];
            qp_raw <= prev_mem[rd_addr[ADDR_W-1:0]];
            ql_raw <= live_mem[rd_addr[ADDR_W-1:0]];
            qd_reg <= data_mem[rd_addr[ADDR_W-1:0]];
            qa_reg <= rd_addr[ADDR_W-1:0];
        end
    end

    always_comb
    begin
        st.kind       = kind_reg;
        st.given      = given_reg;
        st.x_nil      = (x_reg == NIL);
        st.n_nil      = (n_reg == NIL);
        st.cur_nil    = (cur_reg == NIL);
        st.base_nil   = (base_reg == NIL);
        st.free_nil   = (free_reg == NIL);
        st.idx_oob    = (steps_reg >= count_reg);
        st.steps_zero = (steps_reg == '0);
        st.q_live     = q_live;
        st.q_match    = (qd_reg == val_reg);
        st.q_bmatch   = (qd_reg == bval_reg);
        st.out_free   = !ov_reg || !out_stall;
    end

    assign out_valid = ov_reg;
    assign ok        = ores_reg.ok;
    assign data      = ores_reg.data;
    assign handle    = ores_reg.h;
    assign prev_node = ores_reg.p;
    assign has_prev  = ores_reg.hp;
    assign next_node = ores_reg.x;
    assign has_next  = ores_reg.hx;
    assign removed   = orem_reg;
    assign size      = osize_reg;

endmodule

// File: src/pooled_doubly_linked_list.sv
// Top level of the pooled doubly linked list: sequencer plus node-table datapath.
// One item is worked on at a time; the next is taken once the result has moved
// into the output register. Every node table has a single read port with a
// registered read, so each node visit is a read followed by a step on its result.
// at_index walks one node per step; find, reverse and clear walk the list node
// by node, remove_equal also releases each matching node, and unique runs
// roughly n*n/2 node visits. Reset needs no clearing pass: one written bit per
// node stands in for the initial free chain and empty links.
module pooled_doubly_linked_list (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         kind,
    input  logic [7:0]         node,
    input  logic               node_given,
    input  logic [31:0]        value,
    input  logic signed [8:0]  index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               ok,
    output logic [31:0]        data,
    output logic [7:0]         handle,
    output logic [7:0]         prev_node,
    output logic               has_prev,
    output logic [7:0]         next_node,
    output logic               has_next,
    output logic [8:0]         removed,
    output logic [8:0]         size
);
    import pdll_pkg::*;

    cmd_t    cmd;
    status_t st;

    pdll_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    pdll_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .kind       (kind),
        .node       (node),
        .node_given (node_given),
        .value      (value),
        .index      (index),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .ok         (ok),
        .data       (data),
        .handle     (handle),
        .prev_node  (prev_node),
        .has_prev   (has_prev),
        .next_node  (next_node),
        .has_next   (has_next),
        .removed    (removed),
        .size       (size)
    );

endmodule

// File: src/pdll_chk.sv
// Port-level checker for the pooled linked list and its bind to the top level.
`include "pooled_doubly_linked_list_macros.svh"

module pdll_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        ok,
    input logic [31:0] data,
    input logic [7:0]  handle,
    input logic        has_prev,
    input logic        has_next,
    input logic [8:0]  removed,
    input logic [8:0]  size
);

    `PDLL_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(data) && $stable(size), "stalled result changed")
    `PDLL_ASSERT_NXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall, "second item taken while busy")
    `PDLL_ASSERT_IMP(a_fail_clean, clk, rst_n, out_valid && !ok, data == 32'd0 && handle == 8'd0 && removed == 9'd0 && !has_prev && !has_next, "failed result not cleared")
    `PDLL_ASSERT_IMP(a_counts, clk, rst_n, out_valid, size <= 9'd256 && (removed == 9'd0 || ok), "size or removal count out of range")

endmodule

bind pooled_doubly_linked_list pdll_chk u_pdll_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ok        (ok),
    .data      (data),
    .handle    (handle),
    .has_prev  (has_prev),
    .has_next  (has_next),
    .removed   (removed),
    .size      (size)
);
